/* rtl/gdfw_pkg.sv */
// Package for the graph depth-first walk block: vertex width, opcode and
// status codes, the result record and the adjacency store command bundle.
// No dependencies.
`default_nettype none

package gdfw_pkg;

    localparam int VTX_W    = 3;
    localparam int VTX_SPAN = 1 << VTX_W;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_WALK = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_DROP = 1'b1;

    typedef struct packed {
        logic [VTX_W-1:0] visit_vertex;
        logic             last_of_run;
        logic             status;
    } t_result;

    // Enables for the adjacency store ports
    typedef struct packed {
        logic cnt_re;
        logic cnt_we;
        logic tbl_re;
        logic tbl_we;
    } t_store_cmd;

endpackage

`default_nettype wire

/* rtl/gdfw_in_if.sv */
// Request channel of the graph depth-first walk block: valid/ready plus
// the opcode and two vertex fields. Depends on gdfw_pkg.
`default_nettype none

interface gdfw_in_if import gdfw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [VTX_W-1:0] first_vertex;
    logic [VTX_W-1:0] second_vertex;

    modport source (output valid, output opcode, output first_vertex,
                    output second_vertex, input ready);
    modport sink   (input valid, input opcode, input first_vertex,
                    input second_vertex, output ready);
endinterface

`default_nettype wire

/* rtl/gdfw_out_if.sv */
// Result channel of the graph depth-first walk block: valid/ready plus
// the visited vertex, end-of-run flag and status. Depends on gdfw_pkg.
`default_nettype none

interface gdfw_out_if import gdfw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VTX_W-1:0] visit_vertex;
    logic             last_of_run;
    logic             status;

    modport source (output valid, output visit_vertex, output last_of_run,
                    output status, input ready);
    modport sink   (input valid, input visit_vertex, input last_of_run,
                    input status, output ready);
endinterface

`default_nettype wire

/* rtl/gdfw_adj_store.sv */
// Adjacency store: neighbor table memory and per-vertex count memory, both
// with registered reads. Counts read as zero until first written.
// Depends on gdfw_pkg.
`default_nettype none

module gdfw_adj_store import gdfw_pkg::*; #(
    parameter int  NV         = 8,
    parameter int  MAX_DEGREE = 8,
    localparam int IW         = $clog2(NV),
    localparam int DW         = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1,
    localparam int CW         = $clog2(MAX_DEGREE + 1),
    localparam int AW         = IW + DW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_store_cmd    i_cmd,
    input  wire logic [IW-1:0] i_cnt_addr,
    input  wire logic [CW-1:0] i_cnt_wdata,
    output logic      [CW-1:0] o_cnt_rdata,
    input  wire logic [AW-1:0] i_tbl_raddr,
    input  wire logic [AW-1:0] i_tbl_waddr,
    input  wire logic [IW-1:0] i_tbl_wdata,
    output logic      [IW-1:0] o_tbl_rdata
);

    localparam int TBL_DEPTH = 1 << AW;

    logic [IW-1:0] r_tbl [0:TBL_DEPTH-1];
    logic [IW-1:0] r_tbl_q;

    logic [CW-1:0] r_cnt [0:NV-1];
    logic [NV-1:0] r_cnt_vld;
    logic [CW-1:0] r_cnt_q;
    logic          r_cnt_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_we) begin
            r_tbl[i_tbl_waddr] <= i_tbl_wdata;
        end
        if (i_cmd.tbl_re) begin
            r_tbl_q <= r_tbl[i_tbl_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_we) begin
            r_cnt[i_cnt_addr] <= i_cnt_wdata;
        end
        if (i_cmd.cnt_re) begin
            r_cnt_q     <= r_cnt[i_cnt_addr];
            r_cnt_q_vld <= r_cnt_vld[i_cnt_addr];
        end
    end

    // Valid bits stand in for clearing the count memory at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
        end else if (i_cmd.cnt_we) begin
            r_cnt_vld[i_cnt_addr] <= 1'b1;
        end
    end

    assign o_cnt_rdata = r_cnt_q_vld ? r_cnt_q : '0;
    assign o_tbl_rdata = r_tbl_q;

endmodule

`default_nettype wire

/* rtl/gdfw_out_reg.sv */
// Output register of the graph depth-first walk block: holds one result
// while the sink stalls. Depends on gdfw_pkg and gdfw_out_if.
`default_nettype none

module gdfw_out_reg import gdfw_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    output logic         o_free,
    gdfw_out_if.source   o_res
);

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_free             = !r_valid || o_res.ready;
    assign o_res.valid        = r_valid;
    assign o_res.visit_vertex = r_res.visit_vertex;
    assign o_res.last_of_run  = r_res.last_of_run;
    assign o_res.status       = r_res.status;

`ifndef NO_ASSERTIONS
    a_load_when_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result loaded over one not yet taken");
`endif

endmodule

`default_nettype wire

/* rtl/graph_depth_first_walk_top.sv */
// Graph depth-first walk: adjacency lists in a table memory, walk control.
// Add edge: count reads, degree check, list appends unless dropped, then a result.
// Walk: push the start vertex, then for every top-of-stack visit read its
// count and scan its adjacency entries, one entry per cycle unless a new
// vertex waits for the output register; the last visit closes the run.
// One request at a time. Reset clears counts, visited marks and stack.
`default_nettype none

module graph_depth_first_walk_top import gdfw_pkg::*; #(
    parameter int NUM_VERTICES = 8,
    parameter int MAX_DEGREE   = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gdfw_in_if.sink   i_req,
    gdfw_out_if.source o_res
);

    localparam int NV = (NUM_VERTICES < VTX_SPAN) ? NUM_VERTICES : VTX_SPAN;
    localparam int IW = $clog2(NV);
    localparam int DW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int CW = $clog2(MAX_DEGREE + 1);
    localparam int AW = IW + DW;
    localparam int FW = $clog2(NV + 1);

    localparam logic [CW:0]   MAXD    = (CW + 1)'(MAX_DEGREE);
    localparam logic [CW:0]   TWO     = (CW + 1)'(2);
    localparam logic [FW-1:0] FILL_NV = FW'(NV);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ADD_B   = 4'd1;
    localparam logic [3:0] S_ADD_CHK = 4'd2;
    localparam logic [3:0] S_ADD_WB  = 4'd3;
    localparam logic [3:0] S_EMIT    = 4'd4;
    localparam logic [3:0] S_W_START = 4'd5;
    localparam logic [3:0] S_W_TOP   = 4'd6;
    localparam logic [3:0] S_W_CNT   = 4'd7;
    localparam logic [3:0] S_W_SCAN  = 4'd8;
    localparam logic [3:0] S_W_END   = 4'd9;

    logic [3:0]       r_state, n_state;
    logic [VTX_W-1:0] r_a, n_a;
    logic [VTX_W-1:0] r_b, n_b;
    logic [CW-1:0]    r_cnt_a, n_cnt_a;
    logic [CW-1:0]    r_cnt_b, n_cnt_b;
    logic             r_status, n_status;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [DW-1:0]    r_slot, n_slot;
    logic [VTX_W-1:0] r_pend, n_pend;
    logic [FW-1:0]    r_fill, n_fill;
    logic [NV-1:0]    r_visited;
    logic [IW-1:0]    r_stk [0:NV-1];

    t_store_cmd    cmd;
    logic [IW-1:0] cnt_addr;
    logic [CW-1:0] cnt_wdata;
    logic [CW-1:0] cnt_rd;
    logic [AW-1:0] tbl_raddr;
    logic [AW-1:0] tbl_waddr;
    logic [IW-1:0] tbl_wdata;
    logic [IW-1:0] tbl_rd;

    logic          out_load;
    t_result       out_res;
    logic          out_free;

    logic          vis_set;
    logic [IW-1:0] vis_idx;
    logic          push;
    logic [IW-1:0] push_v;
    logic          do_pop;

    logic          accept;
    logic [FW-1:0] fill_m1;
    logic [IW-1:0] top_v;
    logic [CW:0]   cnt_a_x;
    logic [CW:0]   cnt_b_x;
    logic          same;
    logic          drop;
    logic          w_in;
    logic          hit;
    logic [CW-1:0] slot_nx;

    gdfw_adj_store #(
        .NV         (NV),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cnt_addr  (cnt_addr),
        .i_cnt_wdata (cnt_wdata),
        .o_cnt_rdata (cnt_rd),
        .i_tbl_raddr (tbl_raddr),
        .i_tbl_waddr (tbl_waddr),
        .i_tbl_wdata (tbl_wdata),
        .o_tbl_rdata (tbl_rd)
    );

    gdfw_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_res   (out_res),
        .o_free  (out_free),
        .o_res   (o_res)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    assign fill_m1 = r_fill - 1'b1;
    assign top_v   = r_stk[fill_m1[IW-1:0]];
    assign cnt_a_x = {1'b0, r_cnt_a};
    assign cnt_b_x = {1'b0, cnt_rd};
    assign same    = (r_a == r_b);
    assign drop    = same ? ((cnt_a_x + TWO) > MAXD)
                          : ((cnt_a_x >= MAXD) || (cnt_b_x >= MAXD));
    assign w_in    = (32'(tbl_rd) < NV);
    assign hit     = w_in && !r_visited[tbl_rd];
    assign slot_nx = CW'(r_slot) + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_a       = r_a;
        n_b       = r_b;
        n_cnt_a   = r_cnt_a;
        n_cnt_b   = r_cnt_b;
        n_status  = r_status;
        n_cnt     = r_cnt;
        n_slot    = r_slot;
        n_pend    = r_pend;
        n_fill    = r_fill;
        cmd       = '0;
        cnt_addr  = '0;
        cnt_wdata = '0;
        tbl_raddr = '0;
        tbl_waddr = '0;
        tbl_wdata = '0;
        out_load  = 1'b0;
        out_res   = '0;
        vis_set   = 1'b0;
        vis_idx   = '0;
        push      = 1'b0;
        push_v    = '0;
        do_pop    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_a = i_req.first_vertex;
                    n_b = i_req.second_vertex;
                    if (i_req.opcode == OP_WALK) begin
                        n_state = S_W_START;
                    end else if ((32'(i_req.first_vertex) >= NV) ||
                                 (32'(i_req.second_vertex) >= NV)) begin
                        n_status = ST_DROP;
                        n_state  = S_EMIT;
                    end else begin
                        cmd.cnt_re = 1'b1;
                        cnt_addr   = i_req.first_vertex[IW-1:0];
                        n_state    = S_ADD_B;
                    end
                end
            end
            S_ADD_B: begin
                n_cnt_a    = cnt_rd;
                cmd.cnt_re = 1'b1;
                cnt_addr   = r_b[IW-1:0];
                n_state    = S_ADD_CHK;
            end
            S_ADD_CHK: begin
                if (drop) begin
                    n_status = ST_DROP;
                    n_state  = S_EMIT;
                end else begin
                    // Append b to a's list; a self-loop appends again next cycle
                    cmd.tbl_we = 1'b1;
                    tbl_waddr  = {r_a[IW-1:0], r_cnt_a[DW-1:0]};
                    tbl_wdata  = r_b[IW-1:0];
                    cmd.cnt_we = 1'b1;
                    cnt_addr   = r_a[IW-1:0];
                    cnt_wdata  = r_cnt_a + 1'b1;
                    n_cnt_b    = same ? (r_cnt_a + 1'b1) : cnt_rd;
                    n_status   = ST_OK;
                    n_state    = S_ADD_WB;
                end
            end
            S_ADD_WB: begin
                cmd.tbl_we = 1'b1;
                tbl_waddr  = {r_b[IW-1:0], r_cnt_b[DW-1:0]};
                tbl_wdata  = r_a[IW-1:0];
                cmd.cnt_we = 1'b1;
                cnt_addr   = r_b[IW-1:0];
                cnt_wdata  = r_cnt_b + 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_res  = '{visit_vertex: '0, last_of_run: 1'b1,
                                 status: r_status};
                    n_state  = S_IDLE;
                end
            end
            S_W_START: begin
                if (32'(r_a) >= NV) begin
                    n_state = S_IDLE;
                end else begin
                    vis_set = 1'b1;
                    vis_idx = r_a[IW-1:0];
                    push    = 1'b1;
                    push_v  = r_a[IW-1:0];
                    n_fill  = FW'(1);
                    n_pend  = r_a;
                    n_state = S_W_TOP;
                end
            end
            S_W_TOP: begin
                cmd.cnt_re = 1'b1;
                cnt_addr   = top_v;
                n_state    = S_W_CNT;
            end
            S_W_CNT: begin
                n_cnt = cnt_rd;
                if (cnt_rd == '0) begin
                    do_pop = 1'b1;
                end else begin
                    cmd.tbl_re = 1'b1;
                    tbl_raddr  = {top_v, {DW{1'b0}}};
                    n_slot     = '0;
                    n_state    = S_W_SCAN;
                end
            end
            S_W_SCAN: begin
                if (hit) begin
                    // Hold the scan until the previous visit can be sent
                    if (out_free) begin
                        out_load = 1'b1;
                        out_res  = '{visit_vertex: r_pend, last_of_run: 1'b0,
                                     status: ST_OK};
                        n_pend   = VTX_W'(tbl_rd);
                        vis_set  = 1'b1;
                        vis_idx  = tbl_rd;
                        if (r_fill < FILL_NV) begin
                            push   = 1'b1;
                            push_v = tbl_rd;
                            n_fill = r_fill + 1'b1;
                        end
                        n_state = S_W_TOP;
                    end
                end else if (slot_nx < r_cnt) begin
                    cmd.tbl_re = 1'b1;
                    tbl_raddr  = {top_v, slot_nx[DW-1:0]};
                    n_slot     = slot_nx[DW-1:0];
                end else begin
                    do_pop = 1'b1;
                end
            end
            S_W_END: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_res  = '{visit_vertex: r_pend, last_of_run: 1'b1,
                                 status: ST_OK};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_pop) begin
            n_fill  = fill_m1;
            n_state = (fill_m1 == '0) ? S_W_END : S_W_TOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_visited <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (vis_set) begin
                r_visited[vis_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_cnt_a  <= n_cnt_a;
        r_cnt_b  <= n_cnt_b;
        r_status <= n_status;
        r_cnt    <= n_cnt;
        r_slot   <= n_slot;
        r_pend   <= n_pend;
        if (push) begin
            r_stk[r_fill[IW-1:0]] <= push_v;
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("request accepted but controller stayed idle");

    a_stack_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_W_TOP) || (r_state == S_W_CNT) || (r_state == S_W_SCAN))
        |-> (r_fill != '0))
        else $error("walk step with an empty vertex stack");

    a_walk_ends_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W_END) |-> (r_fill == '0))
        else $error("walk closed with vertices left on the stack");

    a_stack_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_fill < FILL_NV) || (r_state == S_W_START))
        else $error("push onto a full vertex stack");
`endif

endmodule

`default_nettype wire

/* verif/graph_depth_first_walk_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for graph_depth_first_walk_top: edge requests and walks in, preorder
// visits out, checked against an adjacency-list graph kept alongside the block.
// Depends on gdfw_pkg, gdfw_in_if, gdfw_out_if and the block itself.

module graph_depth_first_walk_top_tb;
    import gdfw_pkg::*;

    localparam int NUM_VERT    = 8;
    localparam int MAX_DEG     = 8;
    localparam int PHASE_ITEMS = 72;
    localparam int DRAIN_WAIT  = 200;

    typedef struct packed {
        logic             opcode;
        logic [VTX_W-1:0] first_vertex;
        logic [VTX_W-1:0] second_vertex;
    } t_request;

    logic i_clk;
    logic i_rst_n;

    gdfw_in_if  req_if ();
    gdfw_out_if res_if ();

    graph_depth_first_walk_top #(
        .NUM_VERTICES(NUM_VERT),
        .MAX_DEGREE  (MAX_DEG)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    // Graph as the block should hold it
    logic [VTX_W-1:0] adj_list [NUM_VERT][MAX_DEG];
    int               adj_count [NUM_VERT];
    bit               seen [NUM_VERT];

    t_request request_backlog [$];
    t_result  expected_visits [$];
    t_request driven_req;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       mismatch_count;

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.opcode  = OP_ADD;
        req_if.first_vertex  = '0;
        req_if.second_vertex = '0;
        res_if.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        foreach (adj_count[v]) begin
            adj_count[v] = 0;
            seen[v]      = 1'b0;
        end
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // Update the graph for one accepted request and queue the visits it yields
    task automatic apply_to_graph(input t_request r);
        t_result          res;
        logic [VTX_W-1:0] trail [NUM_VERT];
        logic [VTX_W-1:0] path [NUM_VERT];
        int               a;
        int               b;
        int               depth;
        int               n_out;
        int               top;
        int               nxt;
        bit               fits;
        a = int'(r.first_vertex);
        b = int'(r.second_vertex);
        if (r.opcode == OP_ADD) begin
            if (a == b)
                fits = (adj_count[a] + 2 <= MAX_DEG);
            else
                fits = (adj_count[a] < MAX_DEG) && (adj_count[b] < MAX_DEG);
            if (fits) begin
                adj_list[a][adj_count[a]] = VTX_W'(b);
                adj_count[a]++;
                adj_list[b][adj_count[b]] = VTX_W'(a);
                adj_count[b]++;
            end
            res.visit_vertex = '0;
            res.last_of_run  = 1'b1;
            res.status       = fits ? ST_OK : ST_DROP;
            expected_visits.push_back(res);
        end else begin
            // start is emitted even when it was marked by an earlier walk
            seen[a]  = 1'b1;
            trail[0] = VTX_W'(a);
            n_out    = 1;
            path[0]  = VTX_W'(a);
            depth    = 1;
            while (depth > 0) begin
                top = int'(path[depth-1]);
                nxt = -1;
                for (int i = 0; i < adj_count[top]; i++)
                    if (nxt < 0 && !seen[adj_list[top][i]])
                        nxt = int'(adj_list[top][i]);
                if (nxt >= 0) begin
                    seen[nxt]    = 1'b1;
                    trail[n_out] = VTX_W'(nxt);
                    n_out++;
                    if (depth < NUM_VERT) begin
                        path[depth] = VTX_W'(nxt);
                        depth++;
                    end
                end else begin
                    depth--;
                end
            end
            for (int i = 0; i < n_out; i++) begin
                res.visit_vertex = trail[i];
                res.last_of_run  = (i == n_out - 1);
                res.status       = ST_OK;
                expected_visits.push_back(res);
            end
        end
    endtask

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready)
                apply_to_graph(driven_req);
            if (!req_if.valid || req_if.ready) begin
                if (request_backlog.size() != 0 &&
                    $urandom_range(99, 0) >= send_idle_pct) begin
                    driven_req = request_backlog.pop_front();
                    req_if.valid         <= 1'b1;
                    req_if.opcode        <= driven_req.opcode;
                    req_if.first_vertex  <= driven_req.first_vertex;
                    req_if.second_vertex <= driven_req.second_vertex;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_visits.size() == 0) begin
                    report_mismatch("unexpected result, vertex", -1,
                                    int'(res_if.visit_vertex));
                end else begin
                    want = expected_visits.pop_front();
                    if (res_if.visit_vertex !== want.visit_vertex)
                        report_mismatch("visit_vertex", int'(want.visit_vertex),
                                        int'(res_if.visit_vertex));
                    if (res_if.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", int'(want.last_of_run),
                                        int'(res_if.last_of_run));
                    if (res_if.status !== want.status)
                        report_mismatch("status", int'(want.status),
                                        int'(res_if.status));
                end
            end
            res_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    task automatic queue_request(input logic op, input int a, input int b);
        t_request r;
        r.opcode        = op;
        r.first_vertex  = VTX_W'(a);
        r.second_vertex = VTX_W'(b);
        request_backlog.push_back(r);
    endtask

    task automatic wait_requests_taken();
        while (request_backlog.size() != 0 || req_if.valid)
            @(posedge i_clk);
    endtask

    initial begin
        int src_pct [4];
        int snk_pct [4];
        src_pct = '{0, 55, 0, 30};
        snk_pct = '{0, 0, 55, 30};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Build a small tree, walk it deep, then walk again from a marked start
        queue_request(OP_ADD, 0, 1);
        queue_request(OP_ADD, 1, 2);
        queue_request(OP_ADD, 0, 3);
        queue_request(OP_ADD, 3, 4);
        queue_request(OP_ADD, 2, 5);
        queue_request(OP_ADD, 7, 7);
        queue_request(OP_WALK, 1, 7);
        queue_request(OP_WALK, 1, 0);
        // Fill vertex 6 with self-loops, then overflow it
        repeat (4) queue_request(OP_ADD, 6, 6);
        queue_request(OP_ADD, 6, 6);
        queue_request(OP_ADD, 6, 0);
        // Bring vertex 7 to one free entry, then a self-loop must drop whole
        for (int v = 0; v < 5; v++)
            queue_request(OP_ADD, 7, v);
        queue_request(OP_ADD, 7, 7);
        queue_request(OP_ADD, 0, 0);
        queue_request(OP_WALK, 6, 6);
        queue_request(OP_WALK, 7, 0);
        wait_requests_taken();

        for (int ph = 0; ph < 4; ph++) begin
            @(negedge i_clk);
            send_idle_pct  = src_pct[ph];
            recv_stall_pct = snk_pct[ph];
            for (int k = 0; k < PHASE_ITEMS; k++)
                queue_request(($urandom_range(99, 0) < 65) ? OP_ADD : OP_WALK,
                              $urandom_range(NUM_VERT - 1, 0),
                              $urandom_range(NUM_VERT - 1, 0));
            wait_requests_taken();
        end

        while (expected_visits.size() != 0)
            @(posedge i_clk);
        // hold on to catch stray results
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/gdfw_pkg.sv
rtl/gdfw_in_if.sv
rtl/gdfw_out_if.sv
rtl/gdfw_adj_store.sv
rtl/gdfw_out_reg.sv
rtl/graph_depth_first_walk_top.sv
verif/graph_depth_first_walk_top_tb.sv
